[rtl/ksbd_pkg.sv]
package ksbd_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam int IDX_W    = 6;
  localparam int NORM_W   = 19;
  localparam int SIZE_W   = 13;
  localparam int DIST_W   = 25;
  localparam int BRG_W    = 17;
  localparam int COORD_W  = 25;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int VEC_W    = 36;
  localparam int ANG_W    = 32;
  localparam int STEP_W   = 5;
  localparam int GUARD    = 6;
  localparam int LO_W     = 18;
  localparam int HI_W     = 17;
  localparam int PROD_W   = 67;

  localparam logic [31:0]       INV_GAIN     = 32'd2608131496;
  localparam logic [BRG_W-1:0]  BEARING_FULL = 17'd92160;
  localparam logic [ANG_W-1:0]  HALF_TURN    = 32'h8000_0000;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic  capture;
    logic  scale;
    logic  store;
    logic  load_a;
    logic  rd_sel_b;
    logic  load_diff;
    logic  init;
    logic  iter;
    step_t step;
    logic  mul_lo;
    logic  mul_hi;
    logic  finish;
    logic  load_out;
  } ctl_t;

  typedef struct packed {
    logic miss;
  } sts_t;

  function automatic logic [ANG_W-1:0] atan_entry(input step_t i);
    logic [ANG_W-1:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/ksbd_ctrl.sv]
module ksbd_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ksbd_pkg::ctl_t        ctl,
  input  ksbd_pkg::sts_t        sts
);

  localparam int SW = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_WMUL, S_WSTORE, S_RDA, S_RDB, S_DIFF, S_INIT, S_ITER,
    S_MLO, S_MHI, S_FIN, S_DONE
  } state_t;

  state_t          state;
  logic [SW-1:0]   step;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.capture   = (state == S_IDLE) && in_valid;
    ctl.scale     = (state == S_WMUL);
    ctl.store     = (state == S_WSTORE);
    ctl.rd_sel_b  = (state == S_RDB);
    ctl.load_a    = (state == S_RDB);
    ctl.load_diff = (state == S_DIFF);
    ctl.init      = (state == S_INIT);
    ctl.iter      = (state == S_ITER);
    ctl.step      = ksbd_pkg::step_t'(step);
    ctl.mul_lo    = (state == S_MLO);
    ctl.mul_hi    = (state == S_MHI);
    ctl.finish    = (state == S_FIN);
    ctl.load_out  = (state == S_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (ksbd_pkg::cmd_t'(cmd))
              ksbd_pkg::CMD_WRITE: state <= S_WMUL;
              ksbd_pkg::CMD_QUERY: state <= S_RDA;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_WMUL:   state <= S_WSTORE;
        S_WSTORE: state <= S_DONE;
        S_RDA:    state <= sts.miss ? S_DONE : S_RDB;
        S_RDB:    state <= S_DIFF;
        S_DIFF:   state <= S_INIT;
        S_INIT: begin
          step  <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (step == SW'(CORDIC_STEPS - 1)) begin
            state <= S_MLO;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_FIN;
        S_FIN: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/ksbd_datapath.sv]
module ksbd_datapath #(
  parameter int NUM_KEYPOINTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [ksbd_pkg::SIZE_W-1:0]         cfg_data,
  input  logic [1:0]                          cmd,
  input  logic [ksbd_pkg::IDX_W-1:0]          keypoint_index,
  input  logic signed [ksbd_pkg::NORM_W-1:0]  norm_x,
  input  logic signed [ksbd_pkg::NORM_W-1:0]  norm_y,
  input  logic [ksbd_pkg::IDX_W-1:0]          first_index,
  input  logic [ksbd_pkg::IDX_W-1:0]          second_index,
  input  ksbd_pkg::ctl_t                      ctl,
  output ksbd_pkg::sts_t                      sts,
  output logic                                status,
  output logic [ksbd_pkg::DIST_W-1:0]         distance,
  output logic [ksbd_pkg::BRG_W-1:0]          bearing
);

  localparam int DEPTH = (NUM_KEYPOINTS < 64) ? NUM_KEYPOINTS : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ksbd_pkg::COORD_W;
  localparam int VW    = ksbd_pkg::VEC_W;
  localparam int PW    = ksbd_pkg::PROD_W;
  localparam logic [ksbd_pkg::IDX_W:0] DEPTH_C = (ksbd_pkg::IDX_W + 1)'(DEPTH);

  logic [ksbd_pkg::SIZE_W-1:0] image_width, image_height;
  logic [1:0]                  cmd_q;
  logic [ksbd_pkg::IDX_W-1:0]  kidx, ia, ib;
  logic signed [ksbd_pkg::NORM_W-1:0] nx, ny;
  logic                        miss;
  logic [DEPTH-1:0]            valid;
  logic [2*CW-1:0]             mem [DEPTH];
  logic [2*CW-1:0]             rd_data, pa;
  logic signed [CW-1:0]        px, py;
  logic signed [ksbd_pkg::DIFF_W-1:0] dx, dy;
  logic                        zero_len;
  logic signed [VW-1:0]        u, v;
  logic [ksbd_pkg::ANG_W-1:0]  angle;
  logic [49:0]                 plo;
  logic [48:0]                 phi;
  logic [48:0]                 bprod;
  logic [ksbd_pkg::DIST_W-1:0] dist_r;
  logic [ksbd_pkg::BRG_W-1:0]  brg_r;

  logic a_ok, b_ok, kidx_ok;
  logic [AW-1:0] rd_addr;
  logic signed [ksbd_pkg::SIZE_W:0] sw, sh;
  logic signed [32:0] sx, sy;
  logic signed [VW-1:0] u0, v0, su, sv;
  logic [VW-2:0] umag;
  logic [PW-1:0] dsum;
  logic [PW-39:0] dshift;
  logic [49:0] bsum;
  logic [17:0] bq;
  logic is_query;

  assign a_ok    = ({1'b0, first_index} < DEPTH_C) && valid[first_index[AW-1:0]];
  assign b_ok    = ({1'b0, second_index} < DEPTH_C) && valid[second_index[AW-1:0]];
  assign kidx_ok = ({1'b0, kidx} < DEPTH_C);
  assign rd_addr = ctl.rd_sel_b ? ib[AW-1:0] : ia[AW-1:0];
  assign sts.miss = miss;
  assign is_query = (cmd_q == ksbd_pkg::CMD_QUERY);

  assign sw = (image_width == '0)  ? (ksbd_pkg::SIZE_W + 1)'(1) : {1'b0, image_width};
  assign sh = (image_height == '0) ? (ksbd_pkg::SIZE_W + 1)'(1) : {1'b0, image_height};
  assign sx = 33'(nx) * 33'(sw) + 33'sd128;
  assign sy = 33'(ny) * 33'(sh) + 33'sd128;

  assign u0 = -(VW'(dy) <<< ksbd_pkg::GUARD);
  assign v0 = VW'(dx) <<< ksbd_pkg::GUARD;
  assign su = u >>> ctl.step;
  assign sv = v >>> ctl.step;
  assign umag = u[VW-1] ? '0 : u[VW-2:0];

  assign dsum   = PW'(plo) + (PW'(phi) << ksbd_pkg::LO_W) + (PW'(1) << 37);
  assign dshift = dsum[PW-1:38];
  assign bsum   = 50'(bprod) + (50'(1) << 31);
  assign bq     = bsum[49:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ksbd_pkg::SIZE_W'(1);
      image_height <= ksbd_pkg::SIZE_W'(1);
      valid        <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index) begin
          image_height <= cfg_data;
        end else begin
          image_width <= cfg_data;
        end
      end
      if (ctl.capture && (ksbd_pkg::cmd_t'(cmd) == ksbd_pkg::CMD_CLEAR)) begin
        valid <= '0;
      end else if (ctl.store && kidx_ok) begin
        valid[kidx[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store && kidx_ok) begin
      mem[kidx[AW-1:0]] <= {px, py};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd;
      kidx  <= keypoint_index;
      nx    <= norm_x;
      ny    <= norm_y;
      ia    <= first_index;
      ib    <= second_index;
      miss  <= !(a_ok && b_ok);
    end
    if (ctl.scale) begin
      px <= sx[32:8];
      py <= sy[32:8];
    end
    if (ctl.load_a) begin
      pa <= rd_data;
    end
    if (ctl.load_diff) begin
      dx <= ksbd_pkg::DIFF_W'(signed'(rd_data[2*CW-1:CW]))
          - ksbd_pkg::DIFF_W'(signed'(pa[2*CW-1:CW]));
      dy <= ksbd_pkg::DIFF_W'(signed'(rd_data[CW-1:0]))
          - ksbd_pkg::DIFF_W'(signed'(pa[CW-1:0]));
    end
    if (ctl.init) begin
      zero_len <= (dx == '0) && (dy == '0);
      if (u0 < 0) begin
        u     <= -u0;
        v     <= -v0;
        angle <= ksbd_pkg::HALF_TURN;
      end else begin
        u     <= u0;
        v     <= v0;
        angle <= '0;
      end
    end
    if (ctl.iter) begin
      if (!v[VW-1]) begin
        u     <= u + sv;
        v     <= v - su;
        angle <= angle + ksbd_pkg::atan_entry(ctl.step);
      end else begin
        u     <= u - sv;
        v     <= v + su;
        angle <= angle - ksbd_pkg::atan_entry(ctl.step);
      end
    end
    if (ctl.mul_lo) begin
      plo   <= 50'(umag[ksbd_pkg::LO_W-1:0]) * 50'(ksbd_pkg::INV_GAIN);
      bprod <= 49'(angle) * 49'(ksbd_pkg::BEARING_FULL);
    end
    if (ctl.mul_hi) begin
      phi <= 49'(umag[VW-2:ksbd_pkg::LO_W]) * 49'(ksbd_pkg::INV_GAIN);
    end
    if (ctl.finish) begin
      if (zero_len) begin
        dist_r <= '0;
        brg_r  <= '0;
      end else begin
        dist_r <= (dshift > (PW - 38)'({ksbd_pkg::DIST_W{1'b1}}))
                  ? {ksbd_pkg::DIST_W{1'b1}} : dshift[ksbd_pkg::DIST_W-1:0];
        brg_r  <= (bq >= 18'(ksbd_pkg::BEARING_FULL)) ? '0 : bq[ksbd_pkg::BRG_W-1:0];
      end
    end
    if (ctl.load_out) begin
      status   <= is_query && miss;
      distance <= (is_query && !miss) ? dist_r : '0;
      bearing  <= (is_query && !miss) ? brg_r : '0;
    end
  end

endmodule

[rtl/keypoint_segment_bearing_distance.sv]
// Keypoint segment bearing and distance unit. Write transactions scale a normalized point by
// the image size into one of up to 64 slots; clear transactions drop all slots; query
// transactions return the length and clockwise bearing from up of the segment between two
// slots, from an iterative CORDIC in vectoring mode. One transaction is handled at a time:
// a write scales and stores its point; a clear, an unused command or a query naming a
// missing slot goes straight to its result; a good query reads both slots in turn from the
// point memory, which has one read port, and then runs the single shared CORDIC stage
// stepping once per cycle. A finished result waits in the output register while the next
// transaction is accepted.
module keypoint_segment_bearing_distance #(
  parameter int NUM_KEYPOINTS = 64,
  parameter int CORDIC_STEPS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [ksbd_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [ksbd_pkg::IDX_W-1:0]          keypoint_index,
  input  logic signed [ksbd_pkg::NORM_W-1:0]  norm_x,
  input  logic signed [ksbd_pkg::NORM_W-1:0]  norm_y,
  input  logic [ksbd_pkg::IDX_W-1:0]          first_index,
  input  logic [ksbd_pkg::IDX_W-1:0]          second_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                status,
  output logic [ksbd_pkg::DIST_W-1:0]         distance,
  output logic [ksbd_pkg::BRG_W-1:0]          bearing
);

  ksbd_pkg::ctl_t ctl;
  ksbd_pkg::sts_t sts;

  ksbd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  ksbd_datapath #(
    .NUM_KEYPOINTS(NUM_KEYPOINTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .keypoint_index (keypoint_index),
    .norm_x         (norm_x),
    .norm_y         (norm_y),
    .first_index    (first_index),
    .second_index   (second_index),
    .ctl            (ctl),
    .sts            (sts),
    .status         (status),
    .distance       (distance),
    .bearing        (bearing)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block did not go busy after accepting a transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (distance == '0) && (bearing == '0))
    else $error("missing-keypoint result carries a nonzero payload");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing < ksbd_pkg::BEARING_FULL))
    else $error("bearing out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(bearing))
    else $error("stalled result changed");

endmodule

[dv/ksbd_checker.sv]
module ksbd_checker #(
  parameter logic REG_WIDTH  = 1'b0,
  parameter logic REG_HEIGHT = 1'b1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [ksbd_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         cmd,
  input  logic [ksbd_pkg::IDX_W-1:0]         keypoint_index,
  input  logic signed [ksbd_pkg::NORM_W-1:0] norm_x,
  input  logic signed [ksbd_pkg::NORM_W-1:0] norm_y,
  input  logic [ksbd_pkg::IDX_W-1:0]         first_index,
  input  logic [ksbd_pkg::IDX_W-1:0]         second_index,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               status,
  input  logic [ksbd_pkg::DIST_W-1:0]        distance,
  input  logic [ksbd_pkg::BRG_W-1:0]         bearing,
  output int                                 failures,
  output int                                 outstanding
);

  localparam int SLOTS = 64;
  localparam int STEPS = 24;
  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
  localparam logic [63:0] DIST_LIMIT = 64'h1FF_FFFF;
  localparam logic [63:0] TURN_UNITS = 64'd92160;

  localparam logic [31:0] ARCTAN_UNITS [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic                        missing;
    logic [ksbd_pkg::DIST_W-1:0] seg_len;
    logic [ksbd_pkg::BRG_W-1:0]  brg;
  } segment_t;

  logic signed [23:0]          pix_x [SLOTS];
  logic signed [23:0]          pix_y [SLOTS];
  logic                        pix_valid [SLOTS];
  logic [ksbd_pkg::SIZE_W-1:0] width_q;
  logic [ksbd_pkg::SIZE_W-1:0] height_q;
  segment_t                    expected_segments [$];

  function automatic logic signed [23:0] norm_to_pixel(
      input logic signed [ksbd_pkg::NORM_W-1:0] n,
      input logic [ksbd_pkg::SIZE_W-1:0] sz);
    longint p;
    p = longint'(n) * ((sz == 0) ? 64'sd1 : longint'(sz)) + 128;
    return 24'(p >>> 8);
  endfunction

  function automatic segment_t measure_segment(input int a, input int b);
    longint dx, dy, u, v, nu, nv;
    logic [31:0] ang;
    logic [63:0] d, br;
    segment_t r;
    r = '{1'b0, '0, '0};
    if (!pix_valid[a] || !pix_valid[b]) begin
      r.missing = 1'b1;
      return r;
    end
    dx = longint'(pix_x[b]) - longint'(pix_x[a]);
    dy = longint'(pix_y[b]) - longint'(pix_y[a]);
    if (dx == 0 && dy == 0) return r;
    u = -dy * 64;
    v = dx * 64;
    ang = '0;
    if (u < 0) begin
      u = -u;
      v = -v;
      ang = ksbd_pkg::HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (v >= 0) begin
        nu = u + (v >>> i);
        nv = v - (u >>> i);
        ang = ang + ARCTAN_UNITS[i];
      end else begin
        nu = u - (v >>> i);
        nv = v + (u >>> i);
        ang = ang - ARCTAN_UNITS[i];
      end
      u = nu;
      v = nv;
    end
    if (u < 0) u = 0;
    d = (64'(u) * GAIN_Q32 + (64'd1 << 37)) >> 38;
    if (d > DIST_LIMIT) d = DIST_LIMIT;
    br = (64'(ang) * TURN_UNITS + (64'd1 << 31)) >> 32;
    if (br >= TURN_UNITS) br = 0;
    r.seg_len = ksbd_pkg::DIST_W'(d);
    r.brg = ksbd_pkg::BRG_W'(br);
    return r;
  endfunction

  always @(posedge clk) begin
    segment_t exp_seg;
    if (rst) begin
      width_q <= ksbd_pkg::SIZE_W'(1);
      height_q <= ksbd_pkg::SIZE_W'(1);
      foreach (pix_valid[i]) pix_valid[i] = 1'b0;
      expected_segments.delete();
      failures <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) width_q <= cfg_data;
        else if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_segments.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected result transaction status=%0d distance=%0d bearing=%0d",
                     $realtime, status, distance, bearing);
          failures <= failures + 1;
        end else begin
          exp_seg = expected_segments.pop_front();
          if (status !== exp_seg.missing || distance !== exp_seg.seg_len
              || bearing !== exp_seg.brg) begin
            if (failures < 10)
              $display("%0t: mismatch expected status=%0d distance=%0d bearing=%0d, got %0d %0d %0d",
                       $realtime, exp_seg.missing, exp_seg.seg_len, exp_seg.brg,
                       status, distance, bearing);
            failures <= failures + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_seg = '{1'b0, '0, '0};
        if (cmd == ksbd_pkg::CMD_WRITE) begin
          pix_x[keypoint_index] = norm_to_pixel(norm_x, width_q);
          pix_y[keypoint_index] = norm_to_pixel(norm_y, height_q);
          pix_valid[keypoint_index] = 1'b1;
        end else if (cmd == ksbd_pkg::CMD_QUERY) begin
          exp_seg = measure_segment(int'(first_index), int'(second_index));
        end else if (cmd == ksbd_pkg::CMD_CLEAR) begin
          foreach (pix_valid[i]) pix_valid[i] = 1'b0;
        end
        expected_segments.push_back(exp_seg);
      end
      outstanding <= expected_segments.size();
    end
  end

endmodule

[dv/tb.sv]
module tb;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NW = ksbd_pkg::NORM_W;
  localparam int KW = ksbd_pkg::IDX_W;
  localparam int ZW = ksbd_pkg::SIZE_W;
  localparam logic signed [NW-1:0] NORM_MIN = 19'sh40000;
  localparam logic signed [NW-1:0] NORM_MAX = 19'sh3FFFF;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic                             cfg_index = 1'b0;
  logic [ZW-1:0]                    cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       cmd = ksbd_pkg::CMD_CLEAR;
  logic [KW-1:0]                    keypoint_index = '0;
  logic signed [NW-1:0]             norm_x = '0;
  logic signed [NW-1:0]             norm_y = '0;
  logic [KW-1:0]                    first_index = '0;
  logic [KW-1:0]                    second_index = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             status;
  logic [ksbd_pkg::DIST_W-1:0]      distance;
  logic [ksbd_pkg::BRG_W-1:0]       bearing;
  int                               failures;
  int                               outstanding;
  int                               idle_pct = 0;
  int                               stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypoint_segment_bearing_distance i_dut (.*);

  ksbd_checker #(.REG_WIDTH(REG_WIDTH), .REG_HEIGHT(REG_HEIGHT)) i_checker (.*);

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  task automatic send_item(input logic [1:0] c, input logic [KW-1:0] k,
                           input logic [NW-1:0] nx, input logic [NW-1:0] ny,
                           input logic [KW-1:0] a, input logic [KW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd = c;
    keypoint_index = k;
    norm_x = nx;
    norm_y = ny;
    first_index = a;
    second_index = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_size(input logic idx, input logic [ZW-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [NW-1:0] nx, ny;
    logic [KW-1:0] k, a, b;
    r = $urandom_range(99);
    nx = NW'($urandom);
    ny = NW'($urandom);
    k = KW'($urandom);
    a = KW'($urandom);
    b = KW'($urandom);
    if ($urandom_range(9) == 0) nx = $urandom_range(1) ? NORM_MIN : NORM_MAX;
    if ($urandom_range(9) == 0) ny = $urandom_range(1) ? NORM_MIN : NORM_MAX;
    if (r < 45) send_item(ksbd_pkg::CMD_WRITE, k, nx, ny, a, b);
    else if (r < 93) begin
      if ($urandom_range(19) == 0) send_item(ksbd_pkg::CMD_QUERY, k, nx, ny, r[5:0], r[5:0]);
      else send_item(ksbd_pkg::CMD_QUERY, k, nx, ny, a, b);
    end else if (r < 96) send_item(ksbd_pkg::CMD_CLEAR, k, nx, ny, a, b);
    else send_item(CMD_UNUSED, k, nx, ny, a, b);
  endtask

  initial begin
    logic [ZW-1:0] widths [8];
    logic [ZW-1:0] heights [8];
    widths = '{13'd1, 13'd4096, 13'd0, 13'd640, 13'd8191, ZW'($urandom), 13'd4096,
               ZW'($urandom_range(1, 4096))};
    heights = '{13'd1, 13'd4096, 13'd8191, 13'd480, 13'd0, ZW'($urandom), 13'd1,
                ZW'($urandom_range(1, 4096))};
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_size(REG_WIDTH, 13'd4096);
    write_size(REG_HEIGHT, 13'd4096);
    send_item(ksbd_pkg::CMD_WRITE, 6'd0, NORM_MIN, NORM_MAX, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_WRITE, 6'd63, NORM_MAX, NORM_MIN, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_WRITE, 6'd1, '0, '0, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd0, 6'd63);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd63, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd1, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_WRITE, 6'd2, '0, 19'sh100, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_WRITE, 6'd3, 19'sh100, '0, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_WRITE, 6'd4, 19'sh100, 19'sh100, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd1, 6'd2);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd2, 6'd1);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd1, 6'd3);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd3, 6'd1);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd1, 6'd4);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd4, 6'd1);
    send_item(CMD_UNUSED, 6'd5, NORM_MAX, NORM_MAX, 6'd0, 6'd1);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd0, 6'd5);
    send_item(ksbd_pkg::CMD_CLEAR, 6'd0, '0, '0, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd0, 6'd63);
    send_item(ksbd_pkg::CMD_WRITE, 6'd0, 19'sh8000, 19'sh8000, 6'd0, 6'd0);
    send_item(ksbd_pkg::CMD_QUERY, 6'd0, '0, '0, 6'd0, 6'd63);
    drain();

    // Fill every slot so that later queries never read a slot that was never written.
    for (int s = 0; s < 64; s++)
      send_item(ksbd_pkg::CMD_WRITE, KW'(s), NW'($urandom), NW'($urandom), 6'd0, 6'd0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_size(REG_WIDTH, widths[ph]);
      write_size(REG_HEIGHT, heights[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 48; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 48; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 100; n++) begin
        random_item();
        if (ph == 3 && n == 50) begin
          in_valid = 1'b0;
          while (outstanding != 0) @(negedge clk);
        end
      end
    end
    drain();

    if (failures == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
rtl/ksbd_pkg.sv
rtl/ksbd_ctrl.sv
rtl/ksbd_datapath.sv
rtl/keypoint_segment_bearing_distance.sv
dv/ksbd_checker.sv
dv/tb.sv
